// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/ose_pkg.sv -----
// types and constants of the ordered set engine
// no dependencies
`timescale 1ns / 1ps

package ose_pkg;

	localparam int ACT_W       = 3;
	localparam int KEY_FIELD_W = 32;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 40;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_EXISTS = 3'd2,
		ACT_NEXT   = 3'd3,
		ACT_PREV   = 3'd4
	} ose_action_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
	} ose_ctrl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} ose_flags_t;

endpackage

// ----- src/ordered_set_engine.sv -----
// ordered set engine top level: control, the chain of key cells and result selection
// depends on ose_pkg and ose_cell
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct signed keys in ascending order in a chain of
// cells. Each request (insert, delete, exists, next greater, previous smaller)
// gives one result. A request passes a compare state, in which every cell
// compares its key with the request key, and an update state, in which the
// cells shift to insert or delete and the successor or predecessor is picked
// across the chain. A new request is taken in the update state of the one
// before while the output is free; a stalled output holds the update state.
// An insert of a new key into a full set is dropped and flagged by full_res.

module ordered_set_engine #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// action [2:0], key [34:3], zero fill [39:35]
	input  logic [ose_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// hit [0], found_key [32:1], full_res [33], zero fill [39:34]
	output logic [ose_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ose_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic [ACT_W-1:0]            act_s1;
	logic signed [KEY_FIELD_W-1:0] key_s1;
	logic                        m_valid_q;
	logic [OUT_DATA_W-1:0]       m_data_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        upd_go;
	ose_ctrl_t                   ctrl;
	logic signed [KEY_BITS-1:0]  probe;
	logic signed [KEY_BITS-1:0]  keys      [CAPACITY];
	logic signed [KEY_BITS-1:0]  left_key  [CAPACITY];
	logic signed [KEY_BITS-1:0]  right_key [CAPACITY];
	ose_flags_t                  flags     [CAPACITY];
	logic [CAPACITY-1:0]         occ;
	logic [CAPACITY-1:0]         left_lt;
	logic [CAPACITY-1:0]         gt;
	logic [CAPACITY-1:0]         lt_v;
	logic [CAPACITY-1:0]         eq_v;
	logic [CAPACITY-1:0]         sel_next;
	logic [CAPACITY-1:0]         sel_prev;
	logic signed [KEY_BITS-1:0]  next_key;
	logic signed [KEY_BITS-1:0]  prev_key;
	logic                        present;
	logic                        is_full;
	logic                        hit_c;
	logic                        full_c;
	logic signed [KEY_FIELD_W-1:0] found_c;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign upd_go        = (state_q == ST_UPD) && out_free;
	assign s_axis_tready = (state_q == ST_IDLE) || upd_go;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign probe   = KEY_BITS'(key_s1);
	assign present = |eq_v;
	assign is_full = (count_q == CNT_W'(CAPACITY));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go) state_q <= in_acc ? ST_CMP : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctrl.ins_en) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.del_en) begin
				count_q <= count_q - 1'b1;
			end
			if (upd_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1 <= s_axis_tdata[ACT_W-1:0];
			key_s1 <= s_axis_tdata[ACT_W +: KEY_FIELD_W];
		end
		if (upd_go) begin
			m_data_q <= {(OUT_DATA_W - KEY_FIELD_W - 2)'(0), full_c, found_c, hit_c};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// result decode
	always_comb begin
		hit_c   = 1'b0;
		full_c  = 1'b0;
		found_c = '0;
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.ins_en = 1'b0;
		ctrl.del_en = 1'b0;
		unique case (act_s1)
			ACT_INSERT: begin
				hit_c       = !present && !is_full;
				full_c      = !present && is_full;
				ctrl.ins_en = upd_go && !present && !is_full;
			end
			ACT_DELETE: begin
				hit_c       = present;
				ctrl.del_en = upd_go && present;
			end
			ACT_EXISTS: hit_c = present;
			ACT_NEXT: begin
				hit_c   = |gt;
				found_c = KEY_FIELD_W'(next_key);
			end
			ACT_PREV: begin
				hit_c   = |lt_v;
				found_c = KEY_FIELD_W'(prev_key);
			end
			default: hit_c = 1'b0;
		endcase
	end

	// successor and predecessor pick across the chain
	always_comb begin
		next_key = '0;
		prev_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			next_key = next_key | ({KEY_BITS{sel_next[i]}} & keys[i]);
			prev_key = prev_key | ({KEY_BITS{sel_prev[i]}} & keys[i]);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign occ[g]  = (CNT_W'(g) < count_q);
		assign lt_v[g] = flags[g].lt;
		assign eq_v[g] = flags[g].eq;
		assign gt[g]   = occ[g] && !flags[g].lt && !flags[g].eq;

		if (g == 0) begin : g_first
			assign left_key[g] = probe;
			assign left_lt[g]  = 1'b1;
			assign sel_next[g] = gt[g];
		end else begin : g_inner
			assign left_key[g] = keys[g-1];
			assign left_lt[g]  = flags[g-1].lt;
			assign sel_next[g] = gt[g] && !gt[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_key[g] = keys[g];
			assign sel_prev[g]  = lt_v[g];
		end else begin : g_mid
			assign right_key[g] = keys[g+1];
			assign sel_prev[g]  = lt_v[g] && !flags[g+1].lt;
		end

		ose_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[g]),
			.probe     (probe),
			.left_key  (left_key[g]),
			.right_key (right_key[g]),
			.left_lt   (left_lt[g]),
			.key       (keys[g]),
			.flags     (flags[g])
		);
	end

endmodule

// ----- src/ose_cell.sv -----
// one storage cell of the sorted key chain: holds a key, compares it with
// the probe and shifts toward either neighbor; depends on ose_pkg
`timescale 1ns / 1ps

module ose_cell #(
	parameter int KEY_BITS = 32
) (
	input  logic                       clk,
	input  ose_pkg::ose_ctrl_t         ctrl,
	input  logic                       occ,
	input  logic signed [KEY_BITS-1:0] probe,
	input  logic signed [KEY_BITS-1:0] left_key,
	input  logic signed [KEY_BITS-1:0] right_key,
	input  logic                       left_lt,
	output logic signed [KEY_BITS-1:0] key,
	output ose_pkg::ose_flags_t        flags
);
	import ose_pkg::*;

	logic signed [KEY_BITS-1:0] key_q;
	ose_flags_t                 flags_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			flags_q.lt <= occ && (key_q < probe);
			flags_q.eq <= occ && (key_q == probe);
		end
		if (ctrl.ins_en && !flags_q.lt) begin
			key_q <= left_lt ? probe : left_key;
		end else if (ctrl.del_en && !flags_q.lt) begin
			key_q <= right_key;
		end
	end

	assign key   = key_q;
	assign flags = flags_q;

endmodule

// ----- src/ose_checker.sv -----
// port-level checker of the ordered set engine, bound to the top level
// depends on ose_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ose_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [ose_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ose_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ose_pkg::*;

	logic s_acc;
	logic s_acc_d_q;
	logic s_acc_d2_q;

	assign s_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_acc_d_q  <= 1'b0;
			s_acc_d2_q <= 1'b0;
		end else begin
			s_acc_d_q  <= s_acc;
			s_acc_d2_q <= s_acc_d_q;
		end
	end

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// no request taken during the compare cycle
	`ASSERT_NEXT(a_cmp_busy, clk, arst_n, s_acc, !s_axis_tready)
	// the output is valid once a request has passed the compare and update states
	`ASSERT_NEXT(a_result_due, clk, arst_n, s_acc_d2_q, m_axis_tvalid)
	// a dropped insert never reports a hit
	`ASSERT_ALWAYS(a_full_no_hit, clk, arst_n, !(m_axis_tvalid && m_axis_tdata[33] && m_axis_tdata[0]))
	// a nonzero found key comes only with a hit
	`ASSERT_ALWAYS(a_found_hit, clk, arst_n, !(m_axis_tvalid && (m_axis_tdata[32:1] != '0) && !m_axis_tdata[0]))

endmodule

bind ordered_set_engine ose_checker u_ose_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
